>>> hw/rtl/lsb_first_bit_packer_assert.svh
// Assertion macros for the LSB-first bit packer checker.
// Depends on nothing; included by the checker file only.
`ifndef LSB_FIRST_BIT_PACKER_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_ASSERT_SVH

// Same-cycle implication, gated off during reset
`define LSBP_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("lsbp: implication check failed");

// Next-cycle implication, gated off during reset
`define LSBP_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("lsbp: next-cycle check failed");

`endif

>>> hw/rtl/lsbp_pkg.sv
// Shared constants, types and helpers for the LSB-first bit packer.
// No dependencies; used by the interfaces and every module.
package lsbp_pkg;

    localparam int CODE_W            = 64;
    localparam int COUNT_W           = 7;
    localparam int BYTE_W            = 8;
    localparam int FILL_W            = 3;
    localparam int VBITS_W           = 4;
    localparam int NBYTES_W          = COUNT_W - FILL_W;
    localparam int TOTAL_W           = 32;
    localparam int MAX_CODE_BITS_DEF = 64;
    localparam int QUEUE_DEPTH       = 2;

    // Item kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // Per-entry control carried from front to back
    typedef struct packed {
        logic [NBYTES_W-1:0] nbytes;   // bytes to send, 1..8
        logic [VBITS_W-1:0]  vbits;    // valid bits of each byte
        logic [TOTAL_W-1:0]  total;    // running total at the first byte
    } lsbp_meta_t;

    // Clamp a grown sum to the counter range
    function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W:0] s);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

>>> hw/rtl/lsbp_ifs.sv
// Valid/ready channel interfaces for the bit packer: code items in, bytes out.
// Depends on lsbp_pkg.
interface lsbp_code_if;
    import lsbp_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [CODE_W-1:0]  code_value;
    logic [COUNT_W-1:0] bit_count;

    modport source (output valid, kind, code_value, bit_count, input ready);
    modport sink   (input valid, kind, code_value, bit_count, output ready);
endinterface

interface lsbp_byte_if;
    import lsbp_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last_of_run;
    logic [TOTAL_W-1:0] total_bits;

    modport source (output valid, out_byte, valid_bits, last_of_run, total_bits, input ready);
    modport sink   (input valid, out_byte, valid_bits, last_of_run, total_bits, output ready);
endinterface

>>> hw/rtl/lsb_first_bit_packer.sv
// Items pass the queue, then the working entry, then the byte output register.
// Throughput: one item per cycle in while the two-entry queue has room; bytes
// leave one per cycle while the sink is ready; an item completes 0 to 8 bytes.
// Reset: async active-low; clears the partial byte, fill count, bit total,
// queue and output valid.
module lsb_first_bit_packer #(
    parameter int MAX_CODE_BITS = lsbp_pkg::MAX_CODE_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    lsbp_code_if.sink   code_ch,
    lsbp_byte_if.source byte_ch
);
    import lsbp_pkg::*;

    localparam int DATA_W  = MAX_CODE_BITS + BYTE_W;
    localparam int ENTRY_W = DATA_W + $bits(lsbp_meta_t);

    logic               enq_valid, enq_ready;
    logic [DATA_W-1:0]  enq_data;
    lsbp_meta_t         enq_meta;
    logic               deq_valid, deq_ready;
    logic [ENTRY_W-1:0] deq_entry;
    lsbp_meta_t         deq_meta;

    assign deq_meta = lsbp_meta_t'(deq_entry[ENTRY_W-1:DATA_W]);

    lsbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DATA_W        (DATA_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_ch   (code_ch),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_data  (enq_data),
        .enq_meta  (enq_meta)
    );

    lsbp_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_data  ({enq_meta, enq_data}),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_data  (deq_entry)
    );

    lsbp_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DATA_W        (DATA_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_data  (deq_entry[DATA_W-1:0]),
        .deq_meta  (deq_meta),
        .byte_ch   (byte_ch)
    );

endmodule

>>> hw/rtl/lsbp_queue.sv
// Small FIFO between the packer front and back.
// Depends on lsbp_pkg for the depth.
module lsbp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enq_valid,
    output logic             enq_ready,
    input  logic [WIDTH-1:0] enq_data,
    output logic             deq_valid,
    input  logic             deq_ready,
    output logic [WIDTH-1:0] deq_data
);
    import lsbp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_enq, do_deq;

    assign enq_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign deq_valid = (cnt_reg != '0);
    assign deq_data  = mem_reg[rd_ptr_reg];
    assign do_enq    = enq_valid && enq_ready;
    assign do_deq    = deq_valid && deq_ready;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_enq && !do_deq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_deq && !do_enq)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            mem_reg[wr_ptr_reg] <= enq_data;
        end
    end

endmodule

>>> hw/rtl/lsbp_front.sv
// Packer front: accepts code items, merges them into the partial byte and
// queues one entry per item that sends bytes. Depends on lsbp_pkg, lsbp_ifs.
module lsbp_front #(
    parameter int MAX_CODE_BITS = lsbp_pkg::MAX_CODE_BITS_DEF,
    parameter int DATA_W        = MAX_CODE_BITS + lsbp_pkg::BYTE_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lsbp_code_if.sink            code_ch,
    output logic                 enq_valid,
    input  logic                 enq_ready,
    output logic [DATA_W-1:0]    enq_data,
    output lsbp_pkg::lsbp_meta_t enq_meta
);
    import lsbp_pkg::*;

    logic [BYTE_W-1:0]        partial_reg, partial_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [TOTAL_W-1:0]       bw_reg, bw_next;
    logic [COUNT_W-1:0]       count_c;
    logic [MAX_CODE_BITS-1:0] code_mask;
    logic [MAX_CODE_BITS-1:0] code_m;
    logic [DATA_W-1:0]        stream;
    logic [DATA_W-1:0]        rest;
    logic [COUNT_W-1:0]       fill_sum;
    logic [NBYTES_W-1:0]      nbytes;
    logic                     accept;
    logic                     is_flush;

    assign code_ch.ready = enq_ready;
    assign accept        = code_ch.valid && code_ch.ready;
    assign is_flush      = (code_ch.kind == KIND_FLUSH);

    // Clamp the count and drop code bits above it
    assign count_c   = (code_ch.bit_count > COUNT_W'(MAX_CODE_BITS))
                     ? COUNT_W'(MAX_CODE_BITS) : code_ch.bit_count;
    assign code_mask = ~({MAX_CODE_BITS{1'b1}} << count_c);
    assign code_m    = code_ch.code_value[MAX_CODE_BITS-1:0] & code_mask;

    // New bits land above the held ones
    assign stream   = DATA_W'(partial_reg) | (DATA_W'(code_m) << fill_reg);
    assign fill_sum = COUNT_W'(fill_reg) + count_c;
    assign nbytes   = fill_sum[COUNT_W-1:FILL_W];
    assign rest     = stream >> {nbytes, {FILL_W{1'b0}}};

    // Entry build and state update
    always_comb
    begin
        partial_next = partial_reg;
        fill_next    = fill_reg;
        bw_next      = bw_reg;
        enq_valid    = 1'b0;
        if (is_flush)
        begin
            enq_data        = DATA_W'(partial_reg);
            enq_meta.nbytes = NBYTES_W'(1);
            enq_meta.vbits  = VBITS_W'(fill_reg);
            enq_meta.total  = bw_reg;
        end
        else
        begin
            enq_data        = stream;
            enq_meta.nbytes = nbytes;
            enq_meta.vbits  = VBITS_W'(BYTE_W);
            enq_meta.total  = sat_total({1'b0, bw_reg}
                                        + (TOTAL_W+1)'(BYTE_W) - (TOTAL_W+1)'(fill_reg));
        end
        if (accept)
        begin
            if (is_flush)
            begin
                enq_valid    = (fill_reg != '0);
                partial_next = '0;
                fill_next    = '0;
                bw_next      = '0;
            end
            else
            begin
                enq_valid    = (nbytes != '0);
                partial_next = rest[BYTE_W-1:0];
                fill_next    = fill_sum[FILL_W-1:0];
                bw_next      = sat_total({1'b0, bw_reg} + (TOTAL_W+1)'(count_c));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            fill_reg    <= '0;
            bw_reg      <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
            bw_reg      <= bw_next;
        end
    end

endmodule

>>> hw/rtl/lsbp_back.sv
// Packer back: takes queued entries and sends their bytes one per cycle
// while the sink is ready, through an output register. Depends on lsbp_pkg, lsbp_ifs.
module lsbp_back #(
    parameter int MAX_CODE_BITS = lsbp_pkg::MAX_CODE_BITS_DEF,
    parameter int DATA_W        = MAX_CODE_BITS + lsbp_pkg::BYTE_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 deq_valid,
    output logic                 deq_ready,
    input  logic [DATA_W-1:0]    deq_data,
    input  lsbp_pkg::lsbp_meta_t deq_meta,
    lsbp_byte_if.source          byte_ch
);
    import lsbp_pkg::*;

    // Working entry
    logic                w_valid_reg;
    logic [DATA_W-1:0]   w_data_reg;
    logic [NBYTES_W-1:0] w_left_reg;
    logic [VBITS_W-1:0]  w_vbits_reg;
    logic [TOTAL_W-1:0]  w_total_reg;
    // Output register
    logic                o_valid_reg;
    logic [BYTE_W-1:0]   o_byte_reg;
    logic [VBITS_W-1:0]  o_vbits_reg;
    logic                o_last_reg;
    logic [TOTAL_W-1:0]  o_total_reg;

    logic out_load;
    logic w_done;
    logic w_free;
    logic w_load;

    assign out_load  = w_valid_reg && (!o_valid_reg || byte_ch.ready);
    assign w_done    = out_load && (w_left_reg == NBYTES_W'(1));
    assign w_free    = !w_valid_reg || w_done;
    assign w_load    = w_free && deq_valid;
    assign deq_ready = w_free;

    assign byte_ch.valid       = o_valid_reg;
    assign byte_ch.out_byte    = o_byte_reg;
    assign byte_ch.valid_bits  = o_vbits_reg;
    assign byte_ch.last_of_run = o_last_reg;
    assign byte_ch.total_bits  = o_total_reg;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (w_load)
            begin
                w_valid_reg <= 1'b1;
            end
            else if (w_done)
            begin
                w_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (byte_ch.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: shift the entry down a byte per send
    always_ff @(posedge clk)
    begin
        if (w_load)
        begin
            w_data_reg  <= deq_data;
            w_left_reg  <= deq_meta.nbytes;
            w_vbits_reg <= deq_meta.vbits;
            w_total_reg <= deq_meta.total;
        end
        else if (out_load)
        begin
            w_data_reg  <= w_data_reg >> BYTE_W;
            w_left_reg  <= w_left_reg - 1'b1;
            w_total_reg <= sat_total({1'b0, w_total_reg} + (TOTAL_W+1)'(BYTE_W));
        end
        if (out_load)
        begin
            o_byte_reg  <= w_data_reg[BYTE_W-1:0];
            o_vbits_reg <= w_vbits_reg;
            o_last_reg  <= (w_left_reg == NBYTES_W'(1));
            o_total_reg <= w_total_reg;
        end
    end

endmodule

>>> hw/rtl/lsbp_checker.sv
// Port-level checks on the packer byte channel, bound to the top level.
// Depends on lsbp_pkg and lsb_first_bit_packer_assert.svh.
`include "lsb_first_bit_packer_assert.svh"

module lsbp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [lsbp_pkg::BYTE_W-1:0]  out_byte,
    input logic [lsbp_pkg::VBITS_W-1:0] valid_bits,
    input logic                         last_of_run,
    input logic [lsbp_pkg::TOTAL_W-1:0] total_bits
);
    import lsbp_pkg::*;

    // Byte carries 1 to 8 data bits
    `LSBP_ASSERT_IMP(a_vbits_range, clk, rst_n, out_valid, (valid_bits != '0) && (valid_bits <= VBITS_W'(BYTE_W)))
    // A short byte only comes from a flush, which ends its run
    `LSBP_ASSERT_IMP(a_short_is_last, clk, rst_n, out_valid && (valid_bits != VBITS_W'(BYTE_W)), last_of_run)
    // Within a run the next byte follows at once
    `LSBP_ASSERT_NXT(a_run_no_gap, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid)
    // Within a run the total steps by one byte, saturating
    `LSBP_ASSERT_NXT(a_run_total_step, clk, rst_n, out_valid && out_ready && !last_of_run, (($past(total_bits) > (TOTAL_W)'(32'hFFFFFFF7)) ? (total_bits == '1) : (total_bits == $past(total_bits) + TOTAL_W'(BYTE_W))))
    // Stalled byte holds
    `LSBP_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(total_bits))

endmodule

bind lsb_first_bit_packer lsbp_checker u_lsbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (byte_ch.valid),
    .out_ready   (byte_ch.ready),
    .out_byte    (byte_ch.out_byte),
    .valid_bits  (byte_ch.valid_bits),
    .last_of_run (byte_ch.last_of_run),
    .total_bits  (byte_ch.total_bits)
);

>>> dv/tb_lsb_first_bit_packer.sv
`timescale 1ns / 100ps
// Self-checking testbench for lsb_first_bit_packer: directed and random code items.
// Depends on lsbp_pkg, lsbp_ifs and the packer RTL; expected bytes come from an in-bench model.
module tb_lsb_first_bit_packer;
    import lsbp_pkg::*;

    localparam int          MAX_BITS   = MAX_CODE_BITS_DEF;
    localparam logic [31:0] TOTAL_SAT  = 32'hFFFF_FFFF;
    localparam time         RUN_LIMIT  = 12_000_000;  // ns

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [VBITS_W-1:0] vbits;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } packed_byte_t;

    logic clk;
    logic rst_n;

    lsbp_code_if code_ch ();
    lsbp_byte_if byte_ch ();

    lsb_first_bit_packer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .code_ch (code_ch),
        .byte_ch (byte_ch)
    );

    // Packer model state and the bytes it still expects to see
    logic [BYTE_W-1:0]  pk_byte;
    int unsigned        pk_fill;
    logic [TOTAL_W-1:0] pk_total;
    packed_byte_t       pending_bytes[$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned err_count;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Model one accepted item: append bits LSB first, or flush and clear
    function automatic void pack_code(input logic kind, input logic [CODE_W-1:0] code,
                                      input logic [COUNT_W-1:0] count);
        int unsigned  nbits;
        int unsigned  made;
        packed_byte_t b;
        made = 0;
        if (kind == KIND_FLUSH)
        begin
            if (pk_fill != 0)
            begin
                b.data  = pk_byte;
                b.vbits = VBITS_W'(pk_fill);
                b.last  = 1'b1;
                b.total = pk_total;
                pending_bytes.push_back(b);
            end
            pk_byte  = '0;
            pk_fill  = 0;
            pk_total = '0;
            return;
        end
        nbits = (count > MAX_BITS) ? MAX_BITS : count;
        for (int i = 0; i < nbits; i++)
        begin
            pk_byte[pk_fill] = code[i];
            if (pk_total != TOTAL_SAT)
                pk_total = pk_total + 1;
            pk_fill++;
            if (pk_fill == BYTE_W)
            begin
                b.data  = pk_byte;
                b.vbits = VBITS_W'(BYTE_W);
                b.last  = 1'b0;
                b.total = pk_total;
                pending_bytes.push_back(b);
                made++;
                pk_byte = '0;
                pk_fill = 0;
            end
        end
        // final byte of this item carries the run marker
        if (made > 0)
            pending_bytes[$].last = 1'b1;
    endfunction

    // Send one item; valid stays up afterward unless the next call idles
    task automatic send_code(input logic kind, input logic [CODE_W-1:0] code,
                             input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < src_idle_pct)
        begin
            code_ch.valid <= 1'b0;
            @(posedge clk);
        end
        code_ch.valid      <= 1'b1;
        code_ch.kind       <= kind;
        code_ch.code_value <= code;
        code_ch.bit_count  <= count;
        @(posedge clk);
        while (!code_ch.ready)
            @(posedge clk);
        pack_code(kind, code, count);
    endtask

    function automatic logic [CODE_W-1:0] rand_code();
        return {$urandom, $urandom};
    endfunction

    // Stop sending, then wait for every expected byte
    task automatic wait_drained();
        code_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        // allow for the output latency
        repeat (16) @(posedge clk);
    endtask

    // Byte sink: random backpressure and in-order comparison
    always @(posedge clk)
    begin : byte_monitor
        packed_byte_t seen;
        packed_byte_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            seen.data  = byte_ch.out_byte;
            seen.vbits = byte_ch.valid_bits;
            seen.last  = byte_ch.last_of_run;
            seen.total = byte_ch.total_bits;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, actual data=%h vbits=%0d last=%b total=%0d",
                         $time, seen.data, seen.vbits, seen.last, seen.total);
                err_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (seen !== want)
                begin
                    $display("%0t: byte mismatch, expected data=%h vbits=%0d last=%b total=%0d",
                             $time, want.data, want.vbits, want.last, want.total);
                    $display("%0t:                  actual data=%h vbits=%0d last=%b total=%0d",
                             $time, seen.data, seen.vbits, seen.last, seen.total);
                    err_count++;
                end
            end
        end
        byte_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Edge cases: empty and partial flushes, zero and oversized counts, unused bits
    task automatic test_directed_edges();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_code(KIND_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127);  // flush with nothing held
        send_code(KIND_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);    // zero count
        send_code(KIND_APPEND, 64'h0000_0000_0000_0001, 7'd1);
        send_code(KIND_FLUSH,  64'hDEAD_BEEF_0000_1234, 7'd64);   // one-bit partial out
        send_code(KIND_APPEND, 64'h0000_0000_0000_00A5, 7'd8);    // aligned byte
        send_code(KIND_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_code(KIND_APPEND, 64'h0000_0000_0000_0000, 7'd64);
        send_code(KIND_APPEND, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);    // high bits must be dropped
        send_code(KIND_APPEND, 64'h0123_4567_89AB_CDEF, 7'd127);  // clamps to full width
        send_code(KIND_APPEND, 64'hFEDC_BA98_7654_3210, 7'd65);
        send_code(KIND_APPEND, 64'h0000_0000_0000_007F, 7'd7);
        send_code(KIND_APPEND, 64'hFFFF_FFFF_FFFF_FFEA, 7'd5);    // fits inside the held byte
        send_code(KIND_FLUSH,  64'h0, 7'd0);
        send_code(KIND_FLUSH,  64'h0, 7'd0);                      // back to back, empty
        send_code(KIND_APPEND, 64'h5555_5555_5555_5555, 7'd63);
        send_code(KIND_APPEND, 64'h0000_0000_0000_0001, 7'd1);    // completes eighth byte
        send_code(KIND_APPEND, 64'h0000_0000_0000_01FF, 7'd9);
        send_code(KIND_APPEND, 64'hAAAA_AAAA_AAAA_ABCD, 7'd16);
        send_code(KIND_APPEND, 64'h0, 7'd0);
        send_code(KIND_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127);  // one-bit partial out
        send_code(KIND_APPEND, 64'h8000_0000_0000_0000, 7'd64);
        send_code(KIND_FLUSH,  64'h0, 7'd0);
        wait_drained();
    endtask

    // LZW-like stream: 9 to 16 bit codes with random upper garbage, rare flushes
    task automatic test_code_stream(input int unsigned n_items, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(39) == 0)
                send_code(KIND_FLUSH, rand_code(), COUNT_W'($urandom));
            else
                send_code(KIND_APPEND, rand_code(), COUNT_W'($urandom_range(16, 9)));
        end
    endtask

    // Noise: any count including zero and oversized, frequent flushes
    task automatic test_random_noise(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(9) == 0)
                send_code(KIND_FLUSH, rand_code(), COUNT_W'($urandom));
            else
                send_code(KIND_APPEND, rand_code(), COUNT_W'($urandom_range(127)));
        end
    endtask

    initial
    begin
        err_count          = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        pk_byte            = '0;
        pk_fill            = 0;
        pk_total           = '0;
        rst_n              = 1'b0;
        code_ch.valid      = 1'b0;
        code_ch.kind       = KIND_APPEND;
        code_ch.code_value = '0;
        code_ch.bit_count  = '0;
        byte_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_code_stream(100, 0, 0);
        test_code_stream(100, 65, 0);
        test_code_stream(100, 0, 65);
        test_code_stream(80, 32, 32);
        test_random_noise(60, 32, 32);

        wait_drained();
        if (pending_bytes.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lsbp_pkg.sv
hw/rtl/lsbp_ifs.sv
hw/rtl/lsbp_queue.sv
hw/rtl/lsbp_front.sv
hw/rtl/lsbp_back.sv
hw/rtl/lsb_first_bit_packer.sv
hw/rtl/lsbp_checker.sv
dv/tb_lsb_first_bit_packer.sv
